// ===== design/tfe_pkg.sv =====
// ----------------------------------------------------------------------------
// tfe_pkg
// shared types, frame constants and helpers for the telemetry frame encoder
// ----------------------------------------------------------------------------
package tfe_pkg;

    localparam int unsigned POS_W = 5;

    localparam logic [7:0] HDR_SYNC0   = 8'hAA;
    localparam logic [7:0] HDR_SYNC1   = 8'hFF;
    localparam logic [7:0] ID_IMU      = 8'h01;
    localparam logic [7:0] ID_PRESSURE = 8'h02;
    localparam logic [7:0] ID_ATTITUDE = 8'h03;
    localparam logic [7:0] LEN_IMU     = 8'd13;
    localparam logic [7:0] LEN_PRESS   = 8'd14;
    localparam logic [7:0] LEN_ATT     = 8'd7;
    localparam logic [7:0] TIME_MARK0  = 8'h03;
    localparam logic [7:0] TIME_MARK1  = 8'hFC;
    localparam logic [7:0] BYTE_ONE    = 8'h01;
    localparam logic [7:0] BYTE_ZERO   = 8'h00;

    localparam logic [POS_W-1:0] FRAME_LEN_IMU   = 5'd19;
    localparam logic [POS_W-1:0] FRAME_LEN_PRESS = 5'd20;
    localparam logic [POS_W-1:0] FRAME_LEN_ATT   = 5'd13;
    localparam logic [POS_W-1:0] FRAME_LEN_TIME  = 5'd8;

    typedef enum logic [1:0] {
        KIND_IMU      = 2'd0,
        KIND_PRESSURE = 2'd1,
        KIND_ATTITUDE = 2'd2,
        KIND_TIME     = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SEND = 1'b1
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic advance;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic last_byte;
    } t_dp_stat;

    function automatic logic [POS_W-1:0] frame_len(input t_kind kind);
        logic [POS_W-1:0] len;
        unique case (kind)
            KIND_IMU:      len = FRAME_LEN_IMU;
            KIND_PRESSURE: len = FRAME_LEN_PRESS;
            KIND_ATTITUDE: len = FRAME_LEN_ATT;
            KIND_TIME:     len = FRAME_LEN_TIME;
        endcase
        return len;
    endfunction

endpackage

// ===== design/tfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// tfe_ctrl
// frame controller: accepts a record and steps the datapath through its bytes
// ----------------------------------------------------------------------------
module tfe_ctrl
    import tfe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.advance = 1'b0;
        o_busy        = 1'b0;
        o_valid       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEND;
                end
            end
            ST_SEND: begin
                o_busy        = 1'b1;
                o_valid       = 1'b1;
                o_cmd.advance = 1'b1;
                if (i_stat.last_byte) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== design/tfe_dp.sv =====
// ----------------------------------------------------------------------------
// tfe_dp
// frame datapath: held record, byte position, byte select and check sums
// ----------------------------------------------------------------------------
module tfe_dp
    import tfe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [1:0]        i_op,
    input  logic signed [15:0] i_w0,
    input  logic signed [15:0] i_w1,
    input  logic signed [15:0] i_w2,
    input  logic signed [15:0] i_w3,
    input  logic signed [15:0] i_w4,
    input  logic signed [15:0] i_w5,
    input  logic signed [31:0] i_wide,
    output t_dp_stat          o_stat,
    output logic [7:0]        o_out_byte,
    output logic              o_last
);

    t_kind            r_kind;
    logic [15:0]      r_w0, r_w1, r_w2n, r_w3, r_w4, r_w5;
    logic [31:0]      r_wide;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_sum;
    logic [7:0]       r_add;

    logic [POS_W-1:0] len;
    logic             is_sum;
    logic             is_add;
    logic             checked;
    logic [7:0]       data_byte;
    logic [7:0]       n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_IMU;
            r_w0   <= '0;
            r_w1   <= '0;
            r_w2n  <= '0;
            r_w3   <= '0;
            r_w4   <= '0;
            r_w5   <= '0;
            r_wide <= '0;
            r_pos  <= '0;
            r_sum  <= '0;
            r_add  <= '0;
        end else if (i_cmd.load) begin
            r_kind <= t_kind'(i_op);
            r_w0   <= i_w0;
            r_w1   <= i_w1;
            r_w2n  <= 16'(-i_w2);
            r_w3   <= i_w3;
            r_w4   <= i_w4;
            r_w5   <= i_w5;
            r_wide <= i_wide;
            r_pos  <= '0;
            r_sum  <= '0;
            r_add  <= '0;
        end else if (i_cmd.advance) begin
            r_pos <= r_pos + 1'b1;
            if (!is_sum && !is_add) begin
                r_sum <= n_sum;
                r_add <= r_add + n_sum;
            end
        end
    end

    assign len     = frame_len(r_kind);
    assign checked = (r_kind != KIND_TIME);
    assign is_sum  = checked && (r_pos == len - 5'd2);
    assign is_add  = checked && (r_pos == len - 5'd1);
    assign n_sum   = r_sum + data_byte;

    always_comb begin
        data_byte = BYTE_ZERO;
        unique case (r_kind)
            KIND_IMU: begin
                unique case (r_pos)
                    5'd0:    data_byte = HDR_SYNC0;
                    5'd1:    data_byte = HDR_SYNC1;
                    5'd2:    data_byte = ID_IMU;
                    5'd3:    data_byte = LEN_IMU;
                    5'd4:    data_byte = r_w0[7:0];
                    5'd5:    data_byte = r_w0[15:8];
                    5'd6:    data_byte = r_w1[7:0];
                    5'd7:    data_byte = r_w1[15:8];
                    5'd8:    data_byte = 8'(16'(-r_w2n));
                    5'd9:    data_byte = 8'(16'(-r_w2n) >> 8);
                    5'd10:   data_byte = r_w3[7:0];
                    5'd11:   data_byte = r_w3[15:8];
                    5'd12:   data_byte = r_w4[7:0];
                    5'd13:   data_byte = r_w4[15:8];
                    5'd14:   data_byte = r_w5[7:0];
                    5'd15:   data_byte = r_w5[15:8];
                    5'd16:   data_byte = BYTE_ONE;
                    default: data_byte = BYTE_ZERO;
                endcase
            end
            KIND_PRESSURE: begin
                unique case (r_pos)
                    5'd0:    data_byte = HDR_SYNC0;
                    5'd1:    data_byte = HDR_SYNC1;
                    5'd2:    data_byte = ID_PRESSURE;
                    5'd3:    data_byte = LEN_PRESS;
                    5'd10:   data_byte = r_wide[7:0];
                    5'd11:   data_byte = r_wide[15:8];
                    5'd12:   data_byte = r_wide[23:16];
                    5'd13:   data_byte = r_wide[31:24];
                    5'd14:   data_byte = r_w0[7:0];
                    5'd15:   data_byte = r_w0[15:8];
                    5'd16:   data_byte = BYTE_ONE;
                    5'd17:   data_byte = BYTE_ONE;
                    default: data_byte = BYTE_ZERO;
                endcase
            end
            KIND_ATTITUDE: begin
                unique case (r_pos)
                    5'd0:    data_byte = HDR_SYNC0;
                    5'd1:    data_byte = HDR_SYNC1;
                    5'd2:    data_byte = ID_ATTITUDE;
                    5'd3:    data_byte = LEN_ATT;
                    5'd4:    data_byte = r_w0[7:0];
                    5'd5:    data_byte = r_w0[15:8];
                    5'd6:    data_byte = r_w1[7:0];
                    5'd7:    data_byte = r_w1[15:8];
                    5'd8:    data_byte = r_w2n[7:0];
                    5'd9:    data_byte = r_w2n[15:8];
                    default: data_byte = BYTE_ZERO;
                endcase
            end
            KIND_TIME: begin
                unique case (r_pos)
                    5'd0:    data_byte = TIME_MARK0;
                    5'd1:    data_byte = TIME_MARK1;
                    5'd2:    data_byte = r_wide[7:0];
                    5'd3:    data_byte = r_wide[15:8];
                    5'd4:    data_byte = r_wide[23:16];
                    5'd6:    data_byte = TIME_MARK1;
                    5'd7:    data_byte = TIME_MARK0;
                    default: data_byte = BYTE_ZERO;
                endcase
            end
        endcase
    end

    // check bytes replace the data byte at the last two positions, except in time frames
    always_comb begin
        priority if (is_sum) begin
            o_out_byte = r_sum;
        end else if (is_add) begin
            o_out_byte = r_add;
        end else begin
            o_out_byte = data_byte;
        end
    end

    assign o_last           = (r_pos == len - 5'd1);
    assign o_stat.last_byte = o_last;

endmodule

// ===== design/telemetry_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// telemetry_frame_encoder
// turns one telemetry record into a serial byte frame with the last byte marked
// ----------------------------------------------------------------------------
// latency: the first byte appears in the cycle after the start transfer
// throughput: one byte per cycle; a frame holds 8, 13, 19 or 20 bytes, and
//   the next start is taken in the cycle after the last byte; the receiver
//   cannot stall
// reset: synchronous active-low i_rst_n returns the controller to idle and clears the datapath
module telemetry_frame_encoder
    import tfe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_op,
    input  logic signed [15:0] i_w0,
    input  logic signed [15:0] i_w1,
    input  logic signed [15:0] i_w2,
    input  logic signed [15:0] i_w3,
    input  logic signed [15:0] i_w4,
    input  logic signed [15:0] i_w5,
    input  logic signed [31:0] i_wide,
    output logic               o_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_last
);

    // controller to datapath commands and status
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // controller: idle until a start transfer, then one byte per cycle
    tfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_valid (o_valid)
    );

    // datapath: holds the record, selects bytes and runs the check sums
    tfe_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_op       (i_op),
        .i_w0       (i_w0),
        .i_w1       (i_w1),
        .i_w2       (i_w2),
        .i_w3       (i_w3),
        .i_w4       (i_w4),
        .i_w5       (i_w5),
        .i_wide     (i_wide),
        .o_stat     (stat),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

`ifndef SYNTHESIS
    // a start transfer always opens a frame of more than one byte
    a_start_opens_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_valid && !o_last))
        else $error("frame did not start after start transfer");

    // bytes of a frame leave back to back until the last one
    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("gap inside a frame");

    // the block frees up right after the last byte
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> (!o_busy && !o_valid))
        else $error("busy after last byte");
`endif

endmodule
